// ===== sv/hpr_pkg.sv =====
`timescale 1ns / 1ps
package hpr_pkg;

	localparam int MAX_TAPS  = 16;
	localparam int PHASES    = 64;
	localparam int OUT_SHIFT = 12;
	localparam int FRAC_BITS = 16;
	localparam int MAX_WIDTH = 4096;

	localparam int NCH         = 4;
	localparam int SAMPLE_W    = 8;
	localparam int WORD_W      = NCH * SAMPLE_W;
	localparam int COEF_W      = 16;
	localparam int PH_FIELD_W  = 7;
	localparam int TAP_FIELD_W = 4;
	localparam int POS_W       = 28;
	localparam int CNT_W       = 13;
	localparam int IDX_W       = 12;
	localparam int TAPC_W      = 5;
	localparam int WIDTH_W     = 13;
	localparam int CHAN_W      = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 28;

	localparam int TAP_AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TAPN_W     = $clog2(MAX_TAPS + 1);
	localparam int SPAN_W     = TAPN_W + 1;
	localparam int COEF_DEPTH = (PHASES + 1) * MAX_TAPS;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);
	localparam int SIX_W      = $clog2(2 * PHASES);
	localparam int MUL_W      = FRAC_BITS + SIX_W + 1;
	localparam int PHASE_W    = $clog2(PHASES + 1);
	localparam int PROD_W     = SAMPLE_W + 1 + COEF_W;
	localparam int ACC_W      = PROD_W + TAP_AW;
	localparam int ROUND_HALF = 1 << (OUT_SHIFT - 1);

	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [TAPC_W-1:0]  RST_TAP_COUNT = TAPC_W'(4);
	localparam logic [WIDTH_W-1:0] RST_OUT_WIDTH = WIDTH_W'(1);
	localparam logic [CHAN_W-1:0]  RST_CHANNELS  = CHAN_W'(4);
	localparam logic [POS_W-1:0]   RST_START_POS = '0;
	localparam logic [POS_W-1:0]   RST_STEP      = POS_W'(131072);

	localparam logic ACT_COEF  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_COUNT = 3'd0,
		REG_OUT_WIDTH = 3'd1,
		REG_CHANNELS  = 3'd2,
		REG_START_POS = 3'd3,
		REG_STEP      = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} hpr_state_t;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic clear;
		logic rd_v;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
	} mac_sts_t;

	function automatic logic [TAP_AW-1:0] tap_inc(input logic [TAP_AW-1:0] p);
		return (32'(p) == MAX_TAPS - 1) ? '0 : p + TAP_AW'(1);
	endfunction

	function automatic logic [COEF_AW-1:0] coef_addr(input logic [COEF_AW-1:0] ph,
			input logic [COEF_AW-1:0] tp);
		return ph * COEF_AW'(MAX_TAPS) + tp;
	endfunction

	// fraction scaled to twice the phase count, then rounded to the nearest phase
	function automatic logic [PHASE_W-1:0] phase_of(input logic [FRAC_BITS-1:0] frac);
		logic [MUL_W-1:0] prod;
		logic [SIX_W-1:0] six;
		logic [SIX_W:0]   rnd;
		prod = MUL_W'(frac) * MUL_W'(2 * PHASES);
		six  = prod[FRAC_BITS +: SIX_W];
		rnd  = {1'b0, six} + (SIX_W + 1)'(1);
		return PHASE_W'(rnd >> 1);
	endfunction

	function automatic sample_t clamp_px(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] v;
		logic signed [ACC_W:0] sh;
		v  = (ACC_W + 1)'(acc) + (ACC_W + 1)'(ROUND_HALF);
		sh = v >>> OUT_SHIFT;
		if (v < 0) begin
			return '0;
		end else if (sh > (ACC_W + 1)'(255)) begin
			return '1;
		end
		return sh[SAMPLE_W-1:0];
	endfunction

endpackage

// ===== sv/hpr_if.sv =====
`timescale 1ns / 1ps
interface hpr_in_if;
	import hpr_pkg::*;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [PH_FIELD_W-1:0]         coef_phase;
	logic [TAP_FIELD_W-1:0]        coef_tap;
	logic signed [COEF_W-1:0]      coef_value;
	logic [SAMPLE_W-1:0]           sample_0;
	logic [SAMPLE_W-1:0]           sample_1;
	logic [SAMPLE_W-1:0]           sample_2;
	logic [SAMPLE_W-1:0]           sample_3;
	logic                          row_end;

	modport source (output valid, action, coef_phase, coef_tap, coef_value,
		sample_0, sample_1, sample_2, sample_3, row_end, input ready);
	modport sink (input valid, action, coef_phase, coef_tap, coef_value,
		sample_0, sample_1, sample_2, sample_3, row_end, output ready);
endinterface

interface hpr_out_if;
	import hpr_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] result_0;
	logic [SAMPLE_W-1:0] result_1;
	logic [SAMPLE_W-1:0] result_2;
	logic [SAMPLE_W-1:0] result_3;
	logic [IDX_W-1:0]    out_index;
	logic                out_row_last;

	modport source (output valid, result_0, result_1, result_2, result_3,
		out_index, out_row_last, input ready);
	modport sink (input valid, result_0, result_1, result_2, result_3,
		out_index, out_row_last, output ready);
endinterface

interface hpr_cfg_if;
	import hpr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/horizontal_polyphase_reducer.sv =====
`timescale 1ns / 1ps
// Horizontal polyphase shrinker for rows of 8-bit pixels with 1 to 4 channels.
// in_ch carries either a coefficient load (action 0) or a pixel (action 1);
// out_ch carries one filtered pixel with its index in the row; cfg_ch writes
// tap_count, out_width, channels, start_pos and step by index 0..4 and is
// always ready. Write configuration only while the block is idle.
// A coefficient load or a pixel that completes no output leaves the block idle.
// A pixel that completes an output goes through the MAC step, which reads
// each tap in turn through the coefficient and window memory read ports (one
// read each per cycle), then the product register and the accumulator, then
// the load of the output register. The result is valid from the cycle after that load.
// in_ch.ready is low while an output is being computed.
// A finished result waits in the output register; the next item is taken
// while it waits, but a further output holds in the drain step until the
// receiver takes the first.
// Reset clears the configuration to its defaults, the row position and
// counters, and the 16 window valid bits; the coefficient memory is not
// cleared and must be loaded before pixels are sent.
module horizontal_polyphase_reducer (
	input logic     clk,
	input logic     arst_n,
	hpr_in_if.sink  in_ch,
	hpr_out_if.source out_ch,
	hpr_cfg_if.sink cfg_ch
);
	import hpr_pkg::*;

	hpr_state_t state_q, state_d;

	logic [TAPC_W-1:0]  tap_count_q;
	logic [WIDTH_W-1:0] out_width_q;
	logic [CHAN_W-1:0]  channels_q;
	logic [POS_W-1:0]   start_pos_q;
	logic [POS_W-1:0]   step_q;

	logic [POS_W-1:0] position_q;
	logic [CNT_W-1:0] pixel_cnt_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [TAP_AW-1:0] wr_ptr_q;

	logic [TAP_AW-1:0]  rptr_q;
	logic [TAP_AW-1:0]  j_q;
	logic [TAPN_W-1:0]  taps_q;
	logic [PHASE_W-1:0] phase_q;
	logic [CHAN_W-1:0]  nch_q;
	logic [IDX_W-1:0]   oidx_q;
	logic               olast_q;
	logic               rd_v_s1;

	logic                             out_valid_q;
	logic [NCH-1:0][SAMPLE_W-1:0]     result_q;
	logic [IDX_W-1:0]                 out_index_q;
	logic                             out_row_last_q;

	logic in_xfer, pix_xfer, coef_xfer, cfg_xfer, fire, issue, load_out, coef_wr_en;
	logic [TAPN_W-1:0]  taps_eff;
	logic [CHAN_W-1:0]  nch_eff;
	logic [WIDTH_W-1:0] width_eff;
	logic [CNT_W-1:0]   target;
	logic [POS_W-1:0]   inc;
	logic [POS_W:0]     pos_sum;
	logic [POS_W-1:0]   pos_next;
	logic [TAP_AW-1:0]  wr_ptr_nx;
	logic [SPAN_W-1:0]  start_sum;
	logic [TAP_AW-1:0]  rd_start;

	logic [WORD_W-1:0]            win_word;
	logic signed [COEF_W-1:0]     coef_rd;
	mac_ctl_t                     mac_ctl;
	mac_sts_t                     mac_sts;
	logic [NCH-1:0][SAMPLE_W-1:0] mac_px;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;

	assign in_xfer   = in_ch.valid && in_ch.ready;
	assign pix_xfer  = in_xfer && (in_ch.action == ACT_PIXEL);
	assign coef_xfer = in_xfer && (in_ch.action == ACT_COEF);
	assign cfg_xfer  = cfg_ch.valid && cfg_ch.ready;

	assign coef_wr_en = coef_xfer && (32'(in_ch.coef_phase) <= PHASES)
		&& (32'(in_ch.coef_tap) < MAX_TAPS);

	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TAPN_W'(1);
		end else if (32'(tap_count_q) > MAX_TAPS) begin
			taps_eff = TAPN_W'(MAX_TAPS);
		end else begin
			taps_eff = TAPN_W'(tap_count_q);
		end
		if (channels_q == '0) begin
			nch_eff = CHAN_W'(1);
		end else if (32'(channels_q) > NCH) begin
			nch_eff = CHAN_W'(NCH);
		end else begin
			nch_eff = channels_q;
		end
		width_eff = (32'(out_width_q) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : out_width_q;
	end

	assign target = CNT_W'(position_q[POS_W-1:FRAC_BITS]) + CNT_W'(taps_eff) - CNT_W'(1);
	assign fire   = pix_xfer && (out_cnt_q < CNT_W'(width_eff)) && (pixel_cnt_q == target);

	assign inc      = (step_q < ONE_POS) ? ONE_POS : step_q;
	assign pos_sum  = {1'b0, position_q} + {1'b0, inc};
	assign pos_next = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];

	// oldest tap sits taps_eff slots behind the slot after the new pixel
	assign wr_ptr_nx = tap_inc(wr_ptr_q);
	assign start_sum = (TAPN_W'(wr_ptr_nx) >= taps_eff)
		? SPAN_W'(wr_ptr_nx) - SPAN_W'(taps_eff)
		: SPAN_W'(wr_ptr_nx) + SPAN_W'(MAX_TAPS) - SPAN_W'(taps_eff);
	assign rd_start = start_sum[TAP_AW-1:0];

	hpr_coef_store u_coef (
		.clk     (clk),
		.wr_en   (coef_wr_en),
		.wr_addr (coef_addr(COEF_AW'(in_ch.coef_phase), COEF_AW'(in_ch.coef_tap))),
		.wr_data (in_ch.coef_value),
		.rd_addr (coef_addr(COEF_AW'(phase_q), COEF_AW'(j_q))),
		.rd_data (coef_rd)
	);

	hpr_win_store u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pix_xfer),
		.wr_addr (wr_ptr_q),
		.wr_data ({in_ch.sample_3, in_ch.sample_2, in_ch.sample_1, in_ch.sample_0}),
		.rd_addr (rptr_q),
		.rd_data (win_word)
	);

	assign mac_ctl.clear = fire;
	assign mac_ctl.rd_v  = rd_v_s1;

	hpr_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.win_word (win_word),
		.coef     (coef_rd),
		.sts      (mac_sts),
		.px       (mac_px)
	);

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				issue = 1'b1;
				if (TAPN_W'(j_q) == taps_q - TAPN_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// hold until the accumulators settle and the output register frees
				if (!rd_v_s1 && !mac_sts.busy && (!out_valid_q || out_ch.ready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= RST_TAP_COUNT;
			out_width_q <= RST_OUT_WIDTH;
			channels_q  <= RST_CHANNELS;
			start_pos_q <= RST_START_POS;
			step_q      <= RST_STEP;
		end else if (cfg_xfer) begin
			unique case (cfg_ch.index)
				REG_TAP_COUNT: tap_count_q <= cfg_ch.data[TAPC_W-1:0];
				REG_OUT_WIDTH: out_width_q <= cfg_ch.data[WIDTH_W-1:0];
				REG_CHANNELS:  channels_q  <= cfg_ch.data[CHAN_W-1:0];
				REG_START_POS: start_pos_q <= cfg_ch.data[POS_W-1:0];
				REG_STEP:      step_q      <= cfg_ch.data[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= RST_START_POS;
			pixel_cnt_q <= '0;
			out_cnt_q   <= '0;
			wr_ptr_q    <= '0;
		end else if (pix_xfer) begin
			wr_ptr_q <= wr_ptr_nx;
			if (pixel_cnt_q != CNT_MAX) begin
				pixel_cnt_q <= pixel_cnt_q + CNT_W'(1);
			end
			if (fire) begin
				out_cnt_q  <= out_cnt_q + CNT_W'(1);
				position_q <= pos_next;
			end
			// restart the row after this pixel; the window keeps its contents
			if (in_ch.row_end) begin
				position_q  <= start_pos_q;
				pixel_cnt_q <= '0;
				out_cnt_q   <= '0;
			end
		end else if (cfg_xfer && (cfg_ch.index == REG_START_POS) && (pixel_cnt_q == '0)) begin
			position_q <= cfg_ch.data[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
			j_q     <= '0;
			rptr_q  <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (fire) begin
				j_q    <= '0;
				rptr_q <= rd_start;
			end else if (issue) begin
				j_q    <= j_q + TAP_AW'(1);
				rptr_q <= tap_inc(rptr_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			taps_q  <= taps_eff;
			phase_q <= phase_of(position_q[FRAC_BITS-1:0]);
			nch_q   <= nch_eff;
			oidx_q  <= out_cnt_q[IDX_W-1:0];
			olast_q <= ((out_cnt_q + CNT_W'(1)) == CNT_W'(out_width_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int c = 0; c < NCH; c++) begin
				result_q[c] <= (CHAN_W'(c) < nch_q) ? mac_px[c] : '0;
			end
			out_index_q    <= oidx_q;
			out_row_last_q <= olast_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.result_0     = result_q[0];
	assign out_ch.result_1     = result_q[1];
	assign out_ch.result_2     = result_q[2];
	assign out_ch.result_3     = result_q[3];
	assign out_ch.out_index    = out_index_q;
	assign out_ch.out_row_last = out_row_last_q;

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_v_s1 && !mac_sts.busy))
		else $error("accumulate pipeline busy while idle");

	a_out_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DRAIN))
		else $error("output raised outside the drain step");

	a_out_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= CNT_W'(MAX_WIDTH))
		else $error("output count ran past the row limit");

	a_rptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (32'(rptr_q) < MAX_TAPS))
		else $error("window read pointer out of range");

endmodule

// ===== sv/hpr_coef_store.sv =====
`timescale 1ns / 1ps
module hpr_coef_store (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [hpr_pkg::COEF_AW-1:0]        wr_addr,
	input  logic signed [hpr_pkg::COEF_W-1:0]  wr_data,
	input  logic [hpr_pkg::COEF_AW-1:0]        rd_addr,
	output logic signed [hpr_pkg::COEF_W-1:0]  rd_data
);
	import hpr_pkg::*;

	logic signed [COEF_W-1:0] mem [COEF_DEPTH];
	logic signed [COEF_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== sv/hpr_win_store.sv =====
`timescale 1ns / 1ps
module hpr_win_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [hpr_pkg::TAP_AW-1:0]   wr_addr,
	input  logic [hpr_pkg::WORD_W-1:0]   wr_data,
	input  logic [hpr_pkg::TAP_AW-1:0]   rd_addr,
	output logic [hpr_pkg::WORD_W-1:0]   rd_data
);
	import hpr_pkg::*;

	logic [WORD_W-1:0]   mem [MAX_TAPS];
	logic [MAX_TAPS-1:0] valid_q;
	logic [WORD_W-1:0]   rd_word_q;
	logic                rd_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_word_q <= mem[rd_addr];
		rd_ok_q   <= valid_q[rd_addr];
	end

	// a slot never written since reset reads as a black pixel
	assign rd_data = rd_ok_q ? rd_word_q : '0;

endmodule

// ===== sv/hpr_mac.sv =====
`timescale 1ns / 1ps
module hpr_mac (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  hpr_pkg::mac_ctl_t                             ctl,
	input  logic [hpr_pkg::WORD_W-1:0]                    win_word,
	input  logic signed [hpr_pkg::COEF_W-1:0]             coef,
	output hpr_pkg::mac_sts_t                             sts,
	output logic [hpr_pkg::NCH-1:0][hpr_pkg::SAMPLE_W-1:0] px
);
	import hpr_pkg::*;

	logic signed [PROD_W-1:0] prod_s2 [NCH];
	logic                     prod_v_s2;
	logic signed [ACC_W-1:0]  acc_q [NCH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
		end else begin
			prod_v_s2 <= ctl.rd_v;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			if (ctl.rd_v) begin
				prod_s2[c] <= $signed({1'b0, win_word[c*SAMPLE_W +: SAMPLE_W]}) * coef;
			end
			if (ctl.clear) begin
				acc_q[c] <= '0;
			end else if (prod_v_s2) begin
				acc_q[c] <= acc_q[c] + ACC_W'(prod_s2[c]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			px[c] = clamp_px(acc_q[c]);
		end
	end

	assign sts.busy = prod_v_s2;

endmodule

// ===== tb/horizontal_polyphase_reducer_test.sv =====
`timescale 1ns / 1ps
module horizontal_polyphase_reducer_test;
	import hpr_pkg::*;

	localparam int LIMIT_CYCLES  = 500000;
	localparam int SETTLE_CYCLES = MAX_TAPS + 24;
	localparam int RANDOM_ITEMS  = 260;

	typedef struct {
		logic                            action;
		logic [PH_FIELD_W-1:0]           phase;
		logic [TAP_FIELD_W-1:0]          tap;
		logic signed [COEF_W-1:0]        coef;
		logic [NCH-1:0][SAMPLE_W-1:0]    smp;
		logic                            row_end;
	} hpr_item_t;

	typedef struct {
		logic [NCH-1:0][SAMPLE_W-1:0] px;
		logic [IDX_W-1:0]             index;
		logic                         last;
	} hpr_px_t;

	logic clk = 1'b0;
	logic arst_n;

	hpr_in_if  in_ch ();
	hpr_out_if out_ch ();
	hpr_cfg_if cfg_ch ();

	horizontal_polyphase_reducer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	hpr_item_t pixel_feed[$];
	hpr_px_t   filtered_expect[$];
	hpr_item_t in_flight;

	int send_idle_pct = 10;
	int recv_stall_pct = 48;
	int errors = 0;
	int cycles = 0;
	int n_coef = 0;
	int n_pixel = 0;
	int n_out = 0;
	int n_settings = 1;

	// shadow of the shrinker
	logic signed [COEF_W-1:0]     coef_mem [COEF_DEPTH];
	logic [NCH-1:0][SAMPLE_W-1:0] window [MAX_TAPS];
	logic [POS_W-1:0]             pos;
	logic [CNT_W-1:0]             pix_cnt;
	logic [CNT_W-1:0]             out_cnt;
	logic [TAPC_W-1:0]            m_taps;
	logic [WIDTH_W-1:0]           m_width;
	logic [CHAN_W-1:0]            m_chan;
	logic [POS_W-1:0]             m_start;
	logic [POS_W-1:0]             m_step;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SAMPLE_W-1:0] saturate_px(int acc);
		int v;
		v = acc + ROUND_HALF;
		if (v < 0) begin
			return '0;
		end
		v = v >>> OUT_SHIFT;
		return (v > 255) ? SAMPLE_W'(255) : SAMPLE_W'(v);
	endfunction

	function automatic void shrink_model(hpr_item_t it);
		int taps;
		int nch;
		int lim;
		int target;
		int frac;
		int six;
		int ph;
		int acc;
		longint nxt;
		hpr_px_t r;
		if (it.action == ACT_COEF) begin
			if (it.phase <= PHASES && it.tap < MAX_TAPS) begin
				coef_mem[it.phase * MAX_TAPS + it.tap] = it.coef;
			end
			n_coef++;
			return;
		end
		for (int k = MAX_TAPS - 1; k > 0; k--) begin
			window[k] = window[k - 1];
		end
		window[0] = it.smp;
		taps = (m_taps == 0) ? 1 : (m_taps > MAX_TAPS) ? MAX_TAPS : int'(m_taps);
		nch = (m_chan == 0) ? 1 : (m_chan > NCH) ? NCH : int'(m_chan);
		lim = (m_width > MAX_WIDTH) ? MAX_WIDTH : int'(m_width);
		target = int'(pos >> FRAC_BITS) + taps - 1;
		if (int'(out_cnt) < lim && int'(pix_cnt) == target) begin
			frac = int'(pos[FRAC_BITS-1:0]);
			six = (frac * 2 * PHASES) >> FRAC_BITS;
			ph = (six + 1) >> 1;
			for (int c = 0; c < NCH; c++) begin
				acc = 0;
				if (c < nch) begin
					// oldest pixel in the span meets tap 0
					for (int j = 0; j < taps; j++) begin
						acc += int'(window[taps - 1 - j][c]) *
							int'(coef_mem[ph * MAX_TAPS + j]);
					end
					r.px[c] = saturate_px(acc);
				end else begin
					r.px[c] = '0;
				end
			end
			r.index = out_cnt[IDX_W-1:0];
			r.last = (out_cnt + 1'b1 == m_width);
			filtered_expect.push_back(r);
			out_cnt++;
			nxt = longint'(pos) + longint'((m_step < ONE_POS) ? ONE_POS : m_step);
			pos = (nxt > longint'(POS_MAX)) ? POS_MAX : POS_W'(nxt);
		end
		if (pix_cnt != CNT_MAX) begin
			pix_cnt++;
		end
		if (it.row_end) begin
			pos = m_start;
			pix_cnt = '0;
			out_cnt = '0;
		end
		n_pixel++;
	endfunction

	function automatic void apply_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
		case (r)
			REG_TAP_COUNT: begin
				m_taps = d[TAPC_W-1:0];
			end
			REG_OUT_WIDTH: begin
				m_width = d[WIDTH_W-1:0];
			end
			REG_CHANNELS: begin
				m_chan = d[CHAN_W-1:0];
			end
			REG_START_POS: begin
				m_start = d[POS_W-1:0];
				// position follows only at the start of a row
				if (pix_cnt == 0) begin
					pos = d[POS_W-1:0];
				end
			end
			REG_STEP: begin
				m_step = d[POS_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		case ($urandom_range(7))
			0: begin
				return COEF_W'($urandom);
			end
			1: begin
				return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			end
			default: begin
				return COEF_W'(int'($urandom_range(1536)) - 512);
			end
		endcase
	endfunction

	function automatic void load_coef(int ph, int tp, logic signed [COEF_W-1:0] v);
		hpr_item_t it;
		it.action = ACT_COEF;
		it.phase = PH_FIELD_W'(ph);
		it.tap = TAP_FIELD_W'(tp);
		it.coef = v;
		it.smp = $urandom;
		it.row_end = 1'($urandom_range(1));
		pixel_feed.push_back(it);
	endfunction

	function automatic void send_pixel(logic [WORD_W-1:0] s, logic last);
		hpr_item_t it;
		it.action = ACT_PIXEL;
		it.phase = PH_FIELD_W'($urandom);
		it.tap = TAP_FIELD_W'($urandom);
		it.coef = COEF_W'($urandom);
		it.smp = s;
		it.row_end = last;
		pixel_feed.push_back(it);
	endfunction

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		apply_reg(r, d);
	endtask

	task automatic configure(int taps, int width, int chan, int start, int stp);
		write_reg(REG_TAP_COUNT, CFG_DATA_W'(taps));
		write_reg(REG_OUT_WIDTH, CFG_DATA_W'(width));
		write_reg(REG_CHANNELS, CFG_DATA_W'(chan));
		write_reg(REG_START_POS, CFG_DATA_W'(start));
		write_reg(REG_STEP, CFG_DATA_W'(stp));
		n_settings++;
	endtask

	// sample at the falling edge so queue and valid have both settled
	task automatic settle();
		do @(negedge clk);
		while (pixel_feed.size() != 0 || in_ch.valid || filtered_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				shrink_model(in_flight);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_flight = pixel_feed.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.action <= in_flight.action;
					in_ch.coef_phase <= in_flight.phase;
					in_ch.coef_tap <= in_flight.tap;
					in_ch.coef_value <= in_flight.coef;
					in_ch.sample_0 <= in_flight.smp[0];
					in_ch.sample_1 <= in_flight.smp[1];
					in_ch.sample_2 <= in_flight.smp[2];
					in_ch.sample_3 <= in_flight.smp[3];
					in_ch.row_end <= in_flight.row_end;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		hpr_px_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (filtered_expect.size() == 0) begin
					$error("output at index %0d with nothing expected", out_ch.out_index);
					errors++;
				end else begin
					want = filtered_expect.pop_front();
					check_field("result_0", 16'(want.px[0]), 16'(out_ch.result_0));
					check_field("result_1", 16'(want.px[1]), 16'(out_ch.result_1));
					check_field("result_2", 16'(want.px[2]), 16'(out_ch.result_2));
					check_field("result_3", 16'(want.px[3]), 16'(out_ch.result_3));
					check_field("out_index", 16'(want.index), 16'(out_ch.out_index));
					check_field("out_row_last", 16'(want.last), 16'(out_ch.out_row_last));
				end
				n_out++;
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int n_random;
		int rows;
		int len;
		n_random = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_COEF;
		in_ch.coef_phase = '0;
		in_ch.coef_tap = '0;
		in_ch.coef_value = '0;
		in_ch.sample_0 = '0;
		in_ch.sample_1 = '0;
		in_ch.sample_2 = '0;
		in_ch.sample_3 = '0;
		in_ch.row_end = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TAP_COUNT;
		cfg_ch.data = '0;
		for (int k = 0; k < COEF_DEPTH; k++) begin
			coef_mem[k] = '0;
		end
		for (int k = 0; k < MAX_TAPS; k++) begin
			window[k] = '0;
		end
		m_taps = RST_TAP_COUNT;
		m_width = RST_OUT_WIDTH;
		m_chan = RST_CHANNELS;
		m_start = RST_START_POS;
		m_step = RST_STEP;
		pos = RST_START_POS;
		pix_cnt = '0;
		out_cnt = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// start and step fractions move in eighths, so only every eighth phase is read
		for (int ph = 0; ph <= PHASES; ph += 8) begin
			for (int tp = 0; tp < MAX_TAPS; tp++) begin
				load_coef(ph, tp, rand_coef());
			end
		end
		settle();

		// reset settings: extreme coefficients, ignored loads, saturated sums
		load_coef(0, 0, 16'sh7fff);
		load_coef(0, 1, 16'sh8000);
		load_coef(0, 2, 16'sd4096);
		load_coef(0, 3, 16'sd0);
		load_coef(PHASES + 1, 0, -16'sd1);
		load_coef(127, 15, 16'sd123);
		send_pixel(32'h80ff_00ff, 1'b0);
		send_pixel(32'h00ff_ff00, 1'b0);
		send_pixel(32'h7f01_ff80, 1'b0);
		send_pixel(32'hffff_ffff, 1'b0);
		send_pixel(32'h0000_0000, 1'b1);
		settle();

		// widest filter at half-pixel phase, one channel, unit step
		configure(MAX_TAPS, 3, 1, 32'h8000, int'(ONE_POS));
		for (int p = 0; p < 18; p++) begin
			send_pixel($urandom, p == 17);
		end
		settle();

		// fraction just below a quarter rounds up to the quarter phase
		configure(3, 4, NCH, 32'h3E00, int'(ONE_POS));
		for (int p = 0; p < 8; p++) begin
			send_pixel($urandom, p == 7);
		end
		settle();

		// largest step drives the position into saturation after the first output
		configure(1, 2, 3, 3 << FRAC_BITS, int'(POS_MAX));
		for (int p = 0; p < 5; p++) begin
			send_pixel($urandom, p == 4);
		end
		settle();

		configure(2, 2, 2, int'(POS_MAX), 3 << FRAC_BITS);
		for (int p = 0; p < 3; p++) begin
			send_pixel($urandom, p == 2);
		end
		settle();

		while (n_random < RANDOM_ITEMS) begin
			if (n_random >= 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end else if (n_random >= RANDOM_ITEMS / 3) begin
				send_idle_pct = 48;
				recv_stall_pct = 10;
			end
			configure($urandom_range(1, MAX_TAPS),
				($urandom_range(9) == 0) ? MAX_WIDTH : $urandom_range(1, 24),
				$urandom_range(1, NCH),
				$urandom_range(0, 24) << (FRAC_BITS - 3),
				($urandom_range(3) == 0) ? int'(ONE_POS) :
					$urandom_range(8, 24) << (FRAC_BITS - 3));
			rows = $urandom_range(1, 3);
			for (int r = 0; r < rows; r++) begin
				len = $urandom_range(1, 40);
				for (int p = 0; p < len; p++) begin
					if ($urandom_range(11) == 0) begin
						if ($urandom_range(3) == 0) begin
							load_coef($urandom_range(PHASES + 1, 127),
								$urandom_range(MAX_TAPS - 1), rand_coef());
						end else begin
							load_coef($urandom_range(PHASES), $urandom_range(MAX_TAPS - 1),
								rand_coef());
							n_random++;
						end
					end
					// the last row sometimes stays open across the next setting
					send_pixel($urandom,
						p == len - 1 && (r < rows - 1 || $urandom_range(3) != 0));
					n_random++;
				end
			end
			settle();
		end

		settle();
		$display("Run covered %0d coefficient loads and %0d pixels under %0d register settings",
			n_coef, n_pixel, n_settings);
		$display("%0d filtered pixels compared, %0d mismatches", n_out, errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
